### rtl/task_burst_core_classifier_assert.svh
// Assertion macros for the classifier RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TASK_BURST_CORE_CLASSIFIER_ASSERT_SVH
`define TASK_BURST_CORE_CLASSIFIER_ASSERT_SVH
// same-cycle implication
`define TBCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TBCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/tbcc_pkg.sv
// Shared constants, codes and controller/datapath structs for the classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbcc_pkg;
  localparam int HINT_SLOTS = 256;
  localparam int TASK_SLOTS = 256;
  localparam int HINT_IW = (HINT_SLOTS > 1) ? $clog2(HINT_SLOTS) : 1;
  localparam int TASK_IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int HINT_CW = $clog2(HINT_SLOTS + 1);
  localparam int TASK_CW = $clog2(TASK_SLOTS + 1);
  localparam int SCAN_CW = (HINT_CW > TASK_CW) ? HINT_CW : TASK_CW;

  localparam int ID_W     = 22;
  localparam int VAL_W    = 48;
  localparam int ENT_W    = ID_W + VAL_W;
  localparam int WT_W     = 8;
  localparam int TOT_W    = WT_W + 2;
  localparam int PROD_W   = VAL_W + WT_W + 1;
  localparam int IO_NS_W  = 26;
  localparam int IO_W     = IO_NS_W + WT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int DCNT_W   = $clog2(SUM_W + 1);
  localparam int PLACE_W  = 2;
  localparam int IN_FLD_W = ID_W + VAL_W;
  localparam int IN_DATA_W  = ((IN_FLD_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = PLACE_W + VAL_W + 2;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;

  localparam longint unsigned NS_PER_MS   = 64'd1000000;
  localparam longint unsigned IO_TERM_NS  = 64'd50 * NS_PER_MS;
  localparam logic [IO_NS_W-1:0] IO_TERM  = IO_NS_W'(IO_TERM_NS);
  localparam logic [VAL_W-1:0] NEW_PRED   = 48'd20000000;
  localparam logic [TOT_W-1:0] ZERO_WT_DIV = 10'd100;

  localparam logic [VAL_W-1:0] LITTLE_RST = 48'd5000000;
  localparam logic [VAL_W-1:0] BIG_RST    = 48'd50000000;
  localparam logic [WT_W-1:0]  WLAST_RST  = 8'd50;
  localparam logic [WT_W-1:0]  WPHASE_RST = 8'd30;
  localparam logic [WT_W-1:0]  WIO_RST    = 8'd20;

  localparam logic [CFG_IDX_W-1:0] REG_LITTLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WLAST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WPHASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIO    = 3'd4;

  localparam logic [PLACE_W-1:0] PLACE_LITTLE = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_BIG    = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_ANY    = 2'd2;
  localparam logic [PLACE_W-1:0] PLACE_NONE   = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_task;
    logic hint_write;
    logic task_take;
    logic hint_take;
    logic mul_en;
    logic sum_en;
    logic div_start;
    logic pred_hint;
    logic pred_div;
    logic grade;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic op_classify;
    logic pid_zero;
    logic task_ok;
    logic hint_nz;
    logic div_done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

### rtl/task_burst_core_classifier.sv
// Hint write and classify times depend on H and T, the filled slots of the hint
// and task tables (<= 256 each); the table scans (one entry per cycle, stopping
// on a hit) and the 58-step divider set them. Throughput: one request at a time;
// the next request is taken in the cycle after the result is loaded, while it
// waits in the output register. Reset (rst_n low, synchronous) empties both
// tables by clearing their fill counts, reloads the config and holds both ready
// outputs low.
`timescale 1ns / 1ps
`default_nettype none
module task_burst_core_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [21:0] pid, [69:22] hint_value, [71:70] zero
  input  wire logic [tbcc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] op: 0 store hint, 1 classify
  input  wire logic                            in_tuser,
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [1:0] placement, [49:2] prediction, [50] from_hint, [51] hint_stored,
  // [55:52] zero
  output logic      [tbcc_pkg::OUT_DATA_W-1:0] out_tdata,
  // register write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tbcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbcc_pkg::VAL_W-1:0]      cfg_data
);
  import tbcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes are registered and taken whenever out of reset
  assign cfg_ready = rst_n;

  // sequencer: walks the scan, write, lookup, average and grade steps
  tbcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, arithmetic and output register
  tbcc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

### rtl/tbcc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tbcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/tbcc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tbcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbcc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tbcc_pkg::SUM_W-1:0] dividend,
  input  wire logic [tbcc_pkg::TOT_W-1:0] divisor,
  output logic                            done,
  output logic      [tbcc_pkg::SUM_W-1:0] quotient
);
  import tbcc_pkg::*;

  logic              busy_r, done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [TOT_W-1:0]  rem_r, dvs_r;
  logic [SUM_W-1:0]  quo_r;
  logic [TOT_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(SUM_W);
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= qbit ? TOT_W'(trial - {1'b0, dvs_r}) : trial[TOT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

### rtl/tbcc_ctrl.sv
// Sequencing state machine: drives datapath commands from its status.
// Depends on tbcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbcc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire tbcc_pkg::sts_t sts,
  output tbcc_pkg::cmd_t      cmd
);
  import tbcc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_HSCAN = 4'd2;
  localparam logic [3:0] S_TSCAN = 4'd3;
  localparam logic [3:0] S_TCHK  = 4'd4;
  localparam logic [3:0] S_HLOOK = 4'd5;
  localparam logic [3:0] S_HCHK  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_DIVS  = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_GRADE = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.op_classify) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_HSCAN;
        end else if (sts.pid_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_task  = 1'b1;
          state_nxt      = S_TSCAN;
        end
      end
      S_HSCAN: begin
        if (sts.scan_done) begin
          cmd.hint_write = 1'b1;
          state_nxt      = S_FIN;
        end
      end
      S_TSCAN: begin
        if (sts.scan_done) begin
          cmd.task_take = 1'b1;
          state_nxt     = S_TCHK;
        end
      end
      S_TCHK: begin
        if (sts.task_ok) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_HLOOK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_HLOOK: begin
        if (sts.scan_done) begin
          cmd.hint_take = 1'b1;
          state_nxt     = S_HCHK;
        end
      end
      S_HCHK: begin
        if (sts.hint_nz) begin
          cmd.pred_hint = 1'b1;
          state_nxt     = S_GRADE;
        end else begin
          cmd.mul_en = 1'b1;
          state_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.pred_div = 1'b1;
          state_nxt    = S_GRADE;
        end
      end
      S_GRADE: begin
        cmd.grade = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // no request is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);
endmodule
`default_nettype wire

### rtl/tbcc_dp.sv
// Datapath: config registers, hint and task tables, scan unit, averaging
// arithmetic and output register. Depends on tbcc_pkg, tbcc_ram, tbcc_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "task_burst_core_classifier_assert.svh"
module tbcc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tbcc_pkg::cmd_t                  cmd,
  output tbcc_pkg::sts_t                       sts,
  input  wire logic [tbcc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic [tbcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbcc_pkg::VAL_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [tbcc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tbcc_pkg::*;

  // configuration
  logic [VAL_W-1:0] lt_r, bt_r;
  logic [WT_W-1:0]  wl_r, wp_r, wio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r  <= LITTLE_RST;
      bt_r  <= BIG_RST;
      wl_r  <= WLAST_RST;
      wp_r  <= WPHASE_RST;
      wio_r <= WIO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LITTLE: lt_r  <= cfg_data;
        REG_BIG:    bt_r  <= cfg_data;
        REG_WLAST:  wl_r  <= cfg_data[WT_W-1:0];
        REG_WPHASE: wp_r  <= cfg_data[WT_W-1:0];
        REG_WIO:    wio_r <= cfg_data[WT_W-1:0];
        default: ;
      endcase
    end
  end

  // request under work
  logic             op_r;
  logic [ID_W-1:0]  pid_r;
  logic [VAL_W-1:0] hval_r;

  // table fill counts: slots fill in order and are never freed
  logic [HINT_CW-1:0] hint_cnt_r;
  logic [TASK_CW-1:0] task_cnt_r;

  // scan unit
  logic               scan_act_r, scan_task_r, scan_pend_r, scan_done_r, found_r;
  logic [SCAN_CW-1:0] scan_cnt_r, pend_idx_r, found_idx_r, limit;
  logic [VAL_W-1:0]   found_val_r;
  logic [ENT_W-1:0]   hint_rd, task_rd, rd_ent;
  logic               hit, more, issue;

  assign limit  = scan_task_r ? SCAN_CW'(task_cnt_r) : SCAN_CW'(hint_cnt_r);
  assign rd_ent = scan_task_r ? task_rd : hint_rd;
  assign hit    = scan_pend_r && (rd_ent[ID_W-1:0] == pid_r);
  assign more   = (scan_cnt_r < limit);
  assign issue  = scan_act_r && !hit && more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r  <= 1'b0;
      scan_pend_r <= 1'b0;
      scan_done_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      scan_done_r <= 1'b0;
      if (cmd.scan_start) begin
        scan_act_r  <= 1'b1;
        scan_task_r <= cmd.scan_task;
        scan_cnt_r  <= '0;
        scan_pend_r <= 1'b0;
        found_r     <= 1'b0;
      end else if (scan_act_r) begin
        if (hit) begin
          found_r     <= 1'b1;
          found_idx_r <= pend_idx_r;
          found_val_r <= rd_ent[ENT_W-1:ID_W];
          scan_act_r  <= 1'b0;
          scan_pend_r <= 1'b0;
          scan_done_r <= 1'b1;
        end else if (more) begin
          scan_pend_r <= 1'b1;
          pend_idx_r  <= scan_cnt_r;
          scan_cnt_r  <= scan_cnt_r + 1'b1;
        end else if (scan_pend_r) begin
          scan_pend_r <= 1'b0;
        end else begin
          scan_act_r  <= 1'b0;
          scan_done_r <= 1'b1;
        end
      end
    end
  end

  // table writes
  logic               hint_we, task_we;
  logic [HINT_IW-1:0] hint_waddr;
  logic [TASK_IW-1:0] slot_r;
  logic               new_r, task_ok_r;
  logic [VAL_W-1:0]   prev_r, hint_r, pred_r;

  assign hint_we    = cmd.hint_write && (found_r || (hint_cnt_r < HINT_CW'(HINT_SLOTS)));
  assign hint_waddr = found_r ? found_idx_r[HINT_IW-1:0] : hint_cnt_r[HINT_IW-1:0];
  assign task_we    = cmd.grade;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_cnt_r <= '0;
      task_cnt_r <= '0;
    end else begin
      if (hint_we && !found_r) begin
        hint_cnt_r <= hint_cnt_r + 1'b1;
      end
      if (task_we && new_r) begin
        task_cnt_r <= task_cnt_r + 1'b1;
      end
    end
  end

  tbcc_ram #(.WIDTH(ENT_W), .DEPTH(HINT_SLOTS)) u_hint_ram (
    .clk   (clk),
    .we    (hint_we),
    .waddr (hint_waddr),
    .wdata ({hval_r, pid_r}),
    .re    (issue && !scan_task_r),
    .raddr (scan_cnt_r[HINT_IW-1:0]),
    .rdata (hint_rd)
  );

  tbcc_ram #(.WIDTH(ENT_W), .DEPTH(TASK_SLOTS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (slot_r),
    .wdata ({pred_r, pid_r}),
    .re    (issue && scan_task_r),
    .raddr (scan_cnt_r[TASK_IW-1:0]),
    .rdata (task_rd)
  );

  // averaging: (wl + wp) * prev + wio * 50 ms, over the weight total (100 if it is zero)
  logic [TOT_W-1:0]  wtot, total_r;
  logic [WT_W:0]     wsum;
  logic [PROD_W-1:0] prod_r;
  logic [IO_W-1:0]   io_r;
  logic [SUM_W-1:0]  sum_r, quo;
  logic              div_done;

  assign wsum = {1'b0, wl_r} + {1'b0, wp_r};
  assign wtot = TOT_W'(wsum) + TOT_W'(wio_r);

  tbcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (quo)
  );

  // result fields
  logic [PLACE_W-1:0] place_r;
  logic               fh_r, stored_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_tuser;
      pid_r    <= in_tdata[ID_W-1:0];
      hval_r   <= in_tdata[IN_FLD_W-1:ID_W];
      pred_r   <= '0;
      fh_r     <= 1'b0;
      stored_r <= 1'b0;
      place_r  <= PLACE_NONE;
    end
    if (cmd.hint_write) begin
      stored_r <= hint_we;
    end
    if (cmd.task_take) begin
      if (found_r) begin
        slot_r    <= found_idx_r[TASK_IW-1:0];
        prev_r    <= found_val_r;
        new_r     <= 1'b0;
        task_ok_r <= 1'b1;
      end else if (task_cnt_r < TASK_CW'(TASK_SLOTS)) begin
        slot_r    <= task_cnt_r[TASK_IW-1:0];
        prev_r    <= NEW_PRED;
        new_r     <= 1'b1;
        task_ok_r <= 1'b1;
      end else begin
        task_ok_r <= 1'b0;
      end
    end
    if (cmd.hint_take) begin
      hint_r <= found_r ? found_val_r : '0;
    end
    if (cmd.mul_en) begin
      prod_r  <= wsum * prev_r;
      io_r    <= wio_r * IO_TERM;
      total_r <= (wtot == '0) ? ZERO_WT_DIV : wtot;
    end
    if (cmd.sum_en) begin
      sum_r <= SUM_W'(prod_r) + SUM_W'(io_r);
    end
    if (cmd.pred_hint) begin
      pred_r <= hint_r;
      fh_r   <= 1'b1;
    end
    if (cmd.pred_div) begin
      pred_r <= quo[VAL_W-1:0];
    end
    if (cmd.grade) begin
      // little is tested first when the thresholds overlap
      if (pred_r <= lt_r) begin
        place_r <= PLACE_LITTLE;
      end else if (pred_r >= bt_r) begin
        place_r <= PLACE_BIG;
      end else begin
        place_r <= PLACE_ANY;
      end
    end
  end

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_DATA_W'({stored_r, fh_r, pred_r, place_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.scan_done   = scan_done_r;
  assign sts.op_classify = op_r;
  assign sts.pid_zero    = (pid_r == '0);
  assign sts.task_ok     = task_ok_r;
  assign sts.hint_nz     = (hint_r != '0);
  assign sts.div_done    = div_done;
  assign sts.out_free    = out_free;

  `TBCC_ASSERT_IMP(a_hint_cnt_bound, 1'b1, hint_cnt_r <= HINT_CW'(HINT_SLOTS), "hint count past table")
  `TBCC_ASSERT_IMP(a_task_cnt_bound, 1'b1, task_cnt_r <= TASK_CW'(TASK_SLOTS), "task count past table")
  `TBCC_ASSERT_IMP(a_load_free, cmd.out_load, out_free, "result loaded over a pending one")
  `TBCC_ASSERT_IMP(a_done_idle, scan_done_r, !scan_act_r, "scan done while still active")
  `TBCC_ASSERT_NEXT(a_scan_runs, cmd.scan_start, scan_act_r && !found_r, "scan did not start")
endmodule
`default_nettype wire
